// File: design/pdb_pkg.sv
// pdb_pkg: shared types, codes and fixed-point helpers for the porter-duff pixel blender
// no dependencies; imported by every module of the block

package pdb_pkg;

	// blend mode codes
	typedef enum logic [3:0] {
		MODE_SRCOVER  = 4'd0,
		MODE_MUL      = 4'd1,
		MODE_SCREEN   = 4'd2,
		MODE_DARKEN   = 4'd3,
		MODE_LIGHTEN  = 4'd4,
		MODE_DSTOVER  = 4'd5,
		MODE_SRCIN    = 4'd6,
		MODE_DSTIN    = 4'd7,
		MODE_SRCOUT   = 4'd8,
		MODE_DSTOUT   = 4'd9,
		MODE_SRC      = 4'd10,
		MODE_DST      = 4'd11,
		MODE_CLEAR    = 4'd12,
		MODE_SRCATOP  = 4'd13,
		MODE_DSTATOP  = 4'd14,
		MODE_XOR      = 4'd15
	} mode_t;

	// register indexes on the config port
	localparam logic [1:0] REG_BLEND_MODE = 2'd0;
	localparam logic [1:0] REG_SRC_COLOR  = 2'd1;
	localparam logic [1:0] REG_DST_COLOR  = 2'd2;

	localparam logic [31:0] SRC_COLOR_RST = 32'hEA268CFF;
	localparam logic [31:0] DST_COLOR_RST = 32'h0DBFD9FF;

	// composite alpha at or below this gives the zero pixel
	localparam logic [16:0] ALPHA_FLOOR = 17'd6;
	// ceil(2^24 / 257), exact reciprocal for values below 2^24
	localparam logic [32:0] RECIP_257 = 33'd65281;

	typedef logic [27:0] num_t;
	typedef logic [17:0] den_t;

	// per-pixel side info that rides along the divider
	typedef struct packed {
		logic       zero;
		logic [2:0] sat;
		logic [7:0] alpha;
	} pix_ctl_t;

	// unorm product, rounded: (x*y + 32767) / 65535
	function automatic logic [15:0] fx_mul(input logic [15:0] x, input logic [15:0] y);
		logic [32:0] p;
		logic [33:0] t;
		p = {1'b0, ({16'd0, x} * {16'd0, y})} + 33'd32767;
		t = {1'b0, p} + {17'd0, p[32:16]} + 34'd1;
		return t[31:16];
	endfunction

	// byte to 16-bit unorm (b * 257)
	function automatic logic [15:0] to_unit(input logic [7:0] b);
		return {b, b};
	endfunction

endpackage

// File: design/porter_duff_blend_pixel_top.sv
// porter_duff_blend_pixel_top: apb config registers, compositing pipeline and divider
// depends on pdb_pkg, pdb_compose and pdb_div
//
// usage
//   a pixel word (source_coverage, destination_coverage) is taken at each clock
//   edge with start high; busy is tied low, so a new word may enter every cycle.
//   the result word (out_red, out_green, out_blue, out_alpha) is driven for one
//   cycle with done high, once the pixel has passed the four compositing
//   stages and the eight divider stages.
//   throughput is one word per cycle: four compositing stages feed an
//   eight-stage divider that resolves one quotient bit per stage.
//   the receiver cannot stall; every result must be taken when done is high.
//   registers blend_mode, source_color, destination_color sit at byte
//   addresses 0, 4 and 8 of the apb port; the user must see that they are
//   written only while no pixel is in flight; the block does not enforce it.
//   reset clears the pipeline valid bits and loads the register defaults;
//   no result is produced until a word is accepted after reset.

module porter_duff_blend_pixel_top import pdb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  source_coverage,
	input  logic [7:0]  destination_coverage,
	output logic        done,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [3:0]  blend_mode_q;
	logic [31:0] source_color_q;
	logic [31:0] destination_color_q;
	logic        wr_en;
	logic        cmp_valid;
	num_t [2:0]  cmp_num;
	den_t        cmp_den;
	pix_ctl_t    cmp_ctl;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q        <= MODE_SRCOVER;
			source_color_q      <= SRC_COLOR_RST;
			destination_color_q <= DST_COLOR_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_BLEND_MODE: blend_mode_q        <= pwdata[3:0];
				REG_SRC_COLOR:  source_color_q      <= pwdata;
				REG_DST_COLOR:  destination_color_q <= pwdata;
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[3:2])
			REG_BLEND_MODE: prdata = {28'd0, blend_mode_q};
			REG_SRC_COLOR:  prdata = source_color_q;
			REG_DST_COLOR:  prdata = destination_color_q;
			default:        prdata = 32'd0;
		endcase
	end

	pdb_compose u_compose (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.scov      (source_coverage),
		.dcov      (destination_coverage),
		.mode      (blend_mode_q),
		.src_color (source_color_q),
		.dst_color (destination_color_q),
		.out_valid (cmp_valid),
		.num       (cmp_num),
		.den       (cmp_den),
		.ctl       (cmp_ctl)
	);

	pdb_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmp_valid),
		.num       (cmp_num),
		.den       (cmp_den),
		.ctl       (cmp_ctl),
		.out_valid (done),
		.red       (out_red),
		.green     (out_green),
		.blue      (out_blue),
		.alpha     (out_alpha)
	);

	// every accepted word comes out as a result word with done high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##12 done)
		else $error("result word missing after pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 12))
		else $error("result word without accepted pixel");

endmodule

// File: design/pdb_compose.sv
// pdb_compose: premultiply and compositing stages (four register stages)
// depends on pdb_pkg; feeds numerators and denominator to pdb_div

module pdb_compose import pdb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        scov,
	input  logic [7:0]        dcov,
	input  logic [3:0]        mode,
	input  logic [31:0]       src_color,
	input  logic [31:0]       dst_color,
	output logic              out_valid,
	output num_t [2:0]        num,
	output den_t              den,
	output pix_ctl_t          ctl
);

	logic [2:0][15:0] sc, dc;
	logic             v_s1, v_s2, v_s3, v_s4;
	mode_t            mode_s1, mode_s2;
	logic [15:0]      sa_s1, da_s1;
	logic [2:0][15:0] m_s1;
	logic [15:0]      sa_s2, da_s2, isa_s2, ida_s2, so_s2, do_s2, ov_s2;
	logic [2:0][15:0] s_s2, d_s2, b_s2;
	logic [2:0][15:0] p1_s3, p2_s3, p3_s3, pass_s3;
	logic [16:0]      a_s3;
	num_t [2:0]       num_s4;
	den_t             den_s4;
	pix_ctl_t         ctl_s4;

	// straight colors as unorm values
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sc[i] = to_unit(src_color[31-8*i -: 8]);
			dc[i] = to_unit(dst_color[31-8*i -: 8]);
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: coverage alphas and color products
	always_ff @(posedge clk) begin
		mode_s1 <= mode_t'(mode);
		sa_s1   <= fx_mul(to_unit(src_color[7:0]), to_unit(scov));
		da_s1   <= fx_mul(to_unit(dst_color[7:0]), to_unit(dcov));
		for (int i = 0; i < 3; i++)
			m_s1[i] <= fx_mul(sc[i], dc[i]);
	end

	// stage 2: premultiplied colors, area weights and blend term
	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		sa_s2   <= sa_s1;
		da_s2   <= da_s1;
		isa_s2  <= ~sa_s1;
		ida_s2  <= ~da_s1;
		so_s2   <= fx_mul(sa_s1, ~da_s1);
		do_s2   <= fx_mul(da_s1, ~sa_s1);
		ov_s2   <= fx_mul(sa_s1, da_s1);
		for (int i = 0; i < 3; i++) begin
			s_s2[i] <= fx_mul(sc[i], sa_s1);
			d_s2[i] <= fx_mul(dc[i], da_s1);
			case (mode_s1)
				MODE_SCREEN:  b_s2[i] <= 16'(17'(sc[i]) + 17'(dc[i]) - 17'(m_s1[i]));
				MODE_DARKEN:  b_s2[i] <= (sc[i] < dc[i]) ? sc[i] : dc[i];
				MODE_LIGHTEN: b_s2[i] <= (sc[i] > dc[i]) ? sc[i] : dc[i];
				default:      b_s2[i] <= m_s1[i];
			endcase
		end
	end

	// stage 3: operand select per mode and products
	logic [2:0][15:0] x1, y1, x2, y2, x3, y3, pass;
	logic [16:0]      a_nxt;
	always_comb begin
		a_nxt = 17'd0;
		for (int i = 0; i < 3; i++) begin
			x1[i] = 16'd0; y1[i] = 16'd0;
			x2[i] = 16'd0; y2[i] = 16'd0;
			x3[i] = 16'd0; y3[i] = 16'd0;
			pass[i] = 16'd0;
			case (mode_s2) inside
				MODE_MUL, MODE_SCREEN, MODE_DARKEN, MODE_LIGHTEN: begin
					x1[i] = sc[i];   y1[i] = so_s2;
					x2[i] = dc[i];   y2[i] = do_s2;
					x3[i] = b_s2[i]; y3[i] = ov_s2;
				end
				MODE_DSTOVER: begin
					x1[i] = s_s2[i]; y1[i] = ida_s2; pass[i] = d_s2[i];
				end
				MODE_SRCIN:  begin x1[i] = s_s2[i]; y1[i] = da_s2; end
				MODE_DSTIN:  begin x1[i] = d_s2[i]; y1[i] = sa_s2; end
				MODE_SRCOUT: begin x1[i] = s_s2[i]; y1[i] = ida_s2; end
				MODE_DSTOUT: begin x1[i] = d_s2[i]; y1[i] = isa_s2; end
				MODE_SRC:    pass[i] = s_s2[i];
				MODE_DST:    pass[i] = d_s2[i];
				MODE_CLEAR:  pass[i] = 16'd0;
				MODE_SRCATOP: begin
					x1[i] = s_s2[i]; y1[i] = da_s2;
					x2[i] = d_s2[i]; y2[i] = isa_s2;
				end
				MODE_DSTATOP: begin
					x1[i] = d_s2[i]; y1[i] = sa_s2;
					x2[i] = s_s2[i]; y2[i] = ida_s2;
				end
				MODE_XOR: begin
					x1[i] = s_s2[i]; y1[i] = ida_s2;
					x2[i] = d_s2[i]; y2[i] = isa_s2;
				end
				default: begin
					x1[i] = d_s2[i]; y1[i] = isa_s2; pass[i] = s_s2[i];
				end
			endcase
		end
		case (mode_s2) inside
			MODE_MUL, MODE_SCREEN, MODE_DARKEN, MODE_LIGHTEN:
				a_nxt = 17'(sa_s2) + 17'(da_s2) - 17'(ov_s2);
			MODE_DSTOVER:           a_nxt = 17'(da_s2) + 17'(so_s2);
			MODE_SRCIN, MODE_DSTIN: a_nxt = 17'(ov_s2);
			MODE_SRCOUT:            a_nxt = 17'(so_s2);
			MODE_DSTOUT:            a_nxt = 17'(do_s2);
			MODE_SRC, MODE_DSTATOP: a_nxt = 17'(sa_s2);
			MODE_DST, MODE_SRCATOP: a_nxt = 17'(da_s2);
			MODE_CLEAR:             a_nxt = 17'd0;
			MODE_XOR:               a_nxt = 17'(so_s2) + 17'(do_s2);
			default:                a_nxt = 17'(sa_s2) + 17'(do_s2);
		endcase
	end

	always_ff @(posedge clk) begin
		a_s3 <= a_nxt;
		for (int i = 0; i < 3; i++) begin
			p1_s3[i]   <= fx_mul(x1[i], y1[i]);
			p2_s3[i]   <= fx_mul(x2[i], y2[i]);
			p3_s3[i]   <= fx_mul(x3[i], y3[i]);
			pass_s3[i] <= pass[i];
		end
	end

	// stage 4: channel sums, special cases, alpha byte, divider operands
	logic [17:0]      csum [3];
	logic [15:0]      a_clip;
	logic [32:0]      a_prod;
	always_comb begin
		for (int i = 0; i < 3; i++)
			csum[i] = 18'(p1_s3[i]) + 18'(p2_s3[i]) + 18'(p3_s3[i]) + 18'(pass_s3[i]);
		a_clip = a_s3[16] ? 16'hFFFF : a_s3[15:0];
		a_prod = (33'(a_clip) + 33'd128) * RECIP_257;
	end

	always_ff @(posedge clk) begin
		ctl_s4.zero  <= (a_s3 <= ALPHA_FLOOR);
		ctl_s4.alpha <= a_prod[31:24];
		den_s4       <= {a_s3, 1'b0};
		for (int i = 0; i < 3; i++) begin
			ctl_s4.sat[i] <= (csum[i] >= 18'(a_s3));
			num_s4[i]     <= 28'(csum[i]) * 28'd510 + 28'(a_s3);
		end
	end

	assign out_valid = v_s4;
	assign num       = num_s4;
	assign den       = den_s4;
	assign ctl       = ctl_s4;

endmodule

// File: design/pdb_div.sv
// pdb_div: eight-stage restoring divider, one quotient bit per stage, and result select
// depends on pdb_pkg; driven by pdb_compose

module pdb_div import pdb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  num_t [2:0]  num,
	input  den_t        den,
	input  pix_ctl_t    ctl,
	output logic        out_valid,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha
);

	localparam int NSTG = 8;

	logic             v_s   [NSTG+1];
	num_t [2:0]       rem_s [NSTG+1];
	logic [2:0][7:0]  quo_s [NSTG+1];
	den_t             den_s [NSTG+1];
	pix_ctl_t         ctl_s [NSTG+1];

	assign v_s[0]   = in_valid;
	assign rem_s[0] = num;
	assign quo_s[0] = '0;
	assign den_s[0] = den;
	assign ctl_s[0] = ctl;

	for (genvar k = 1; k <= NSTG; k++) begin : g_stg
		localparam int SH = NSTG - k;
		logic [27:0] dsh;
		logic [2:0]  ge;

		// trial subtract of the shifted divisor
		always_comb begin
			dsh = 28'(den_s[k-1]) << SH;
			for (int i = 0; i < 3; i++)
				ge[i] = (rem_s[k-1][i] >= dsh);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else
				v_s[k] <= v_s[k-1];
		end

		always_ff @(posedge clk) begin
			den_s[k] <= den_s[k-1];
			ctl_s[k] <= ctl_s[k-1];
			for (int i = 0; i < 3; i++) begin
				rem_s[k][i] <= ge[i] ? rem_s[k-1][i] - dsh : rem_s[k-1][i];
				quo_s[k][i] <= {quo_s[k-1][i][6:0], ge[i]};
			end
		end
	end

	// zero pixel, saturated channels, or quotient
	logic [2:0][7:0] chan;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (ctl_s[NSTG].zero)
				chan[i] = 8'd0;
			else if (ctl_s[NSTG].sat[i])
				chan[i] = 8'd255;
			else
				chan[i] = quo_s[NSTG][i];
		end
	end

	assign out_valid = v_s[NSTG];
	assign red       = chan[0];
	assign green     = chan[1];
	assign blue      = chan[2];
	assign alpha     = ctl_s[NSTG].zero ? 8'd0 : ctl_s[NSTG].alpha;

endmodule
